// ----- rtl/core/tce_pkg.sv -----
package tce_pkg;

  localparam int QW    = 40;  // Q16.24 word width
  localparam int FRAC  = 24;  // fraction bits
  localparam int HALFW = 20;  // multiplier operand slice
  localparam int PW    = 55;  // truncated product magnitude width
  localparam int WW    = 58;  // wide update sum width
  localparam int CW    = 17;  // result code width
  localparam int RW    = 39;  // escape radius width
  localparam int IW    = 12;  // iteration count width

  // opcodes
  localparam logic OP_ESCAPE = 1'b0;
  localparam logic OP_STEP   = 1'b1;

  // configuration register indexes
  localparam logic [1:0] REG_C_REAL     = 2'd0;
  localparam logic [1:0] REG_C_IMAG     = 2'd1;
  localparam logic [1:0] REG_RADIUS_SQ  = 2'd2;
  localparam logic [1:0] REG_MAX_ITER   = 2'd3;

  // result codes
  localparam logic [CW-1:0] CODE_BOUNDED = {CW{1'b1}};
  localparam logic [CW-1:0] CODE_STEP    = '0;
  localparam logic [CW-1:0] CODE_NEG_ADD = 17'd21;

  // reset values
  localparam logic [QW-1:0] RST_C_REAL    = 40'hFFFF400000;
  localparam logic [QW-1:0] RST_C_IMAG    = '0;
  localparam logic [RW-1:0] RST_RADIUS_SQ = 39'd167772160000;
  localparam logic [IW-1:0] RST_MAX_ITER  = 12'd100;

  typedef struct packed {
    logic signed [QW-1:0] c_real;
    logic signed [QW-1:0] c_imag;
    logic [RW-1:0]        radius_sq;
    logic [IW-1:0]        max_iter;
  } cfg_t;

  typedef struct packed {
    logic                 hi;      // high operand slice, closes the product
    logic [QW-1:0]        a_mag;
    logic [HALFW-1:0]     b_half;
  } mul_req_t;

  typedef struct packed {
    logic [CW-1:0]        code;
    logic signed [QW-1:0] re;
    logic signed [QW-1:0] im;
  } res_t;

endpackage

// ----- rtl/core/tce_mul.sv -----
module tce_mul
  import tce_pkg::*;
(
  input  logic          clk,
  input  mul_req_t      req,
  output logic [PW-1:0] res_r
);

  logic [2*HALFW+QW-HALFW-1:0] pp_r;
  logic [2*HALFW+QW-HALFW-1:0] acc_r;
  logic                        hi_d_r;
  logic [2*QW-1:0]             sum;

  // combine low and high partial products of the 40x40 magnitude product
  assign sum = (2*QW)'(acc_r) + ((2*QW)'(pp_r) << HALFW);

  // multiply one slice, then accumulate and drop the fraction
  always_ff @(posedge clk) begin
    pp_r   <= req.a_mag * req.b_half;
    hi_d_r <= req.hi;
    if (!hi_d_r) begin
      acc_r <= pp_r;
    end else begin
      res_r <= sum[FRAC+PW-1:FRAC];
    end
  end

endmodule

// ----- rtl/core/tce_core.sv -----
module tce_core
  import tce_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  cfg_t                 cfg,
  input  logic                 start,
  input  logic                 opcode,
  input  logic signed [QW-1:0] start_re,
  input  logic signed [QW-1:0] start_im,
  output logic                 ready,
  output logic                 done,
  input  logic                 done_ack,
  output res_t                 res
);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DONE} state_t;

  state_t               state_r;
  logic [2:0]           step_r;
  logic                 op_r;
  logic signed [QW-1:0] re_r;
  logic signed [QW-1:0] im_r;
  logic [IW-1:0]        cnt_r;
  logic [PW-1:0]        rr_r;
  logic [PW-1:0]        ii_r;
  logic                 neg_r;
  logic [CW-1:0]        code_r;

  logic [QW-1:0]        mag_re;
  logic [QW-1:0]        mag_im;
  logic [QW-1:0]        opb;
  mul_req_t             req;
  logic [PW-1:0]        mul_res;
  logic [PW:0]          norm;
  logic                 escaped;
  logic signed [WW-1:0] c_re_w;
  logic signed [WW-1:0] c_im_w;
  logic signed [WW-1:0] two_ri;
  logic signed [WW-1:0] nr;
  logic signed [WW-1:0] ni;
  logic [CW-1:0]        esc_code;

  function automatic logic signed [QW-1:0] sat_q(input logic signed [WW-1:0] v);
    logic signed [QW-1:0] r;
    if (&v[WW-1:QW-1] || ~|v[WW-1:QW-1]) begin
      r = v[QW-1:0];
    end else if (v[WW-1]) begin
      r = {1'b1, {(QW-1){1'b0}}};
    end else begin
      r = {1'b0, {(QW-1){1'b1}}};
    end
    return r;
  endfunction

  assign mag_re = re_r[QW-1] ? QW'(-re_r) : QW'(re_r);
  assign mag_im = im_r[QW-1] ? QW'(-im_r) : QW'(im_r);

  // feed the shared multiplier: re*re, im*im, re*im, two slices each
  always_comb begin
    req.a_mag = mag_re;
    opb       = mag_re;
    unique case (step_r[2:1])
      2'd0: begin
        req.a_mag = mag_re;
        opb       = mag_re;
      end
      2'd1: begin
        req.a_mag = mag_im;
        opb       = mag_im;
      end
      default: begin
        req.a_mag = mag_re;
        opb       = mag_im;
      end
    endcase
    req.hi     = step_r[0];
    req.b_half = step_r[0] ? opb[QW-1:HALFW] : opb[HALFW-1:0];
  end

  tce_mul u_mul (
    .clk   (clk),
    .req   (req),
    .res_r (mul_res)
  );

  // escape test on the squared norm, ii arrives at step 5
  assign norm    = {1'b0, rr_r} + {1'b0, mul_res};
  assign escaped = !(norm < (PW+1)'(cfg.radius_sq));
  assign esc_code = {{(CW-IW-3){1'b0}}, cnt_r, 3'b000} +
                    (im_r[QW-1] ? CODE_NEG_ADD : {CW{1'b0}});

  // map update, ri arrives at step 7
  assign c_re_w = {{(WW-QW){cfg.c_real[QW-1]}}, cfg.c_real};
  assign c_im_w = {{(WW-QW){cfg.c_imag[QW-1]}}, cfg.c_imag};
  assign two_ri = {{(WW-PW-1){1'b0}}, mul_res, 1'b0};
  assign nr     = $signed({{(WW-PW){1'b0}}, rr_r}) - $signed({{(WW-PW){1'b0}}, ii_r}) + c_re_w;
  assign ni     = neg_r ? c_im_w + two_ri : c_im_w - two_ri;

  // sequencer and orbit registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            state_r <= S_RUN;
            step_r  <= '0;
            op_r    <= opcode;
            re_r    <= start_re;
            im_r    <= start_im;
            cnt_r   <= '0;
          end
        end
        S_RUN: begin
          step_r <= step_r + 3'd1;
          unique case (step_r)
            3'd3: begin
              rr_r  <= mul_res;
              neg_r <= re_r[QW-1] ^ im_r[QW-1];
            end
            3'd5: begin
              ii_r <= mul_res;
              if (op_r == OP_ESCAPE) begin
                if (cnt_r >= cfg.max_iter) begin
                  code_r  <= CODE_BOUNDED;
                  state_r <= S_DONE;
                end else if (escaped) begin
                  code_r  <= esc_code;
                  state_r <= S_DONE;
                end
              end
            end
            3'd7: begin
              re_r  <= sat_q(nr);
              im_r  <= sat_q(ni);
              cnt_r <= cnt_r + 1'b1;
              if (op_r == OP_STEP) begin
                code_r  <= CODE_STEP;
                state_r <= S_DONE;
              end
            end
            default: ;
          endcase
        end
        S_DONE: begin
          if (done_ack) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign ready    = (state_r == S_IDLE);
  assign done     = (state_r == S_DONE);
  assign res.code = code_r;
  assign res.re   = re_r;
  assign res.im   = im_r;

endmodule

// ----- rtl/core/tricorn_escape_time.sv -----
// Tricorn Julia escape-time engine, signed Q16.24 fixed point.
// Input stream: in_tdata carries the start point, in_tuser the opcode
// (0 escape-time count, 1 one map step). A word is taken when in_tvalid
// and in_tready are both high; in_tready is high only while the engine
// is idle, so one point is worked on at a time.
// Output stream: out_tdata carries result code and final point. A
// result waits in the output register until out_tready; the engine
// already takes the next word meanwhile, and holds its own finished
// result until that register is free.
// Each map step runs on the single shared 40x20 multiplier
// (three products of two slices each, then the update). The cfg_
// port writes c, the squared escape radius and the iteration limit;
// write it only while idle.
// Reset (rst_n low, synchronous) empties the engine and the output
// register and loads c = -0.75, radius^2 = 10000.0, limit = 100.
module tricorn_escape_time
  import tce_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [79:0]   in_tdata,   // [39:0] start_real, [79:40] start_imag
  input  logic          in_tuser,   // [0] opcode
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [103:0]  out_tdata,  // [16:0] result_code, [56:17] final_real,
                                    // [96:57] final_imag, [103:97] zero
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [39:0]   cfg_wdata
);

  cfg_t  cfg_r;
  logic  core_ready;
  logic  core_done;
  logic  load_out;
  res_t  core_res;
  res_t  out_r;
  logic  out_valid_r;

  // hold configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.c_real    <= RST_C_REAL;
      cfg_r.c_imag    <= RST_C_IMAG;
      cfg_r.radius_sq <= RST_RADIUS_SQ;
      cfg_r.max_iter  <= RST_MAX_ITER;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_C_REAL:    cfg_r.c_real    <= cfg_wdata;
        REG_C_IMAG:    cfg_r.c_imag    <= cfg_wdata;
        REG_RADIUS_SQ: cfg_r.radius_sq <= cfg_wdata[RW-1:0];
        REG_MAX_ITER:  cfg_r.max_iter  <= cfg_wdata[IW-1:0];
        default: ;
      endcase
    end
  end

  assign in_tready = core_ready;

  tce_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .start    (in_tvalid && core_ready),
    .opcode   (in_tuser),
    .start_re (in_tdata[39:0]),
    .start_im (in_tdata[79:40]),
    .ready    (core_ready),
    .done     (core_done),
    .done_ack (load_out),
    .res      (core_res)
  );

  // move a finished result into the output register when it is free
  assign load_out = core_done && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_r <= core_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_r.im, out_r.re, out_r.code};

endmodule
